@@ rtl/core/spn_pkg.sv @@
package spn_pkg;

    localparam int ROUNDS_DEF = 16;
    localparam int BLK_BYTES  = 16;
    localparam int BLK_BITS   = 128;

    typedef enum logic [1:0] {
        FN_KEY  = 2'd0,
        FN_ENC  = 2'd1,
        FN_DEC  = 2'd2,
        FN_CLR  = 2'd3
    } t_func;

    typedef struct packed {
        logic [1:0] func;
        logic [4:0] key_round;
        logic [3:0] key_byte_index;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] result_byte;
        logic       last_of_block;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KEYRD,
        ST_ROUND,
        ST_FINAL,
        ST_OUT
    } t_state;

    function automatic logic [7:0] fwd_sbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[x];
    endfunction

    function automatic logic [7:0] inv_sbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
        return t[x];
    endfunction

    function automatic logic [3:0] nib_fwd(input logic [3:0] x);
        logic [3:0] t [16];
        t = '{4'd1,4'd6,4'd15,4'd8,4'd5,4'd7,4'd2,4'd10,
              4'd13,4'd12,4'd0,4'd4,4'd14,4'd3,4'd11,4'd9};
        return t[x];
    endfunction

    function automatic logic [3:0] nib_inv(input logic [3:0] x);
        logic [3:0] t [16];
        t = '{4'd10,4'd0,4'd6,4'd13,4'd11,4'd4,4'd1,4'd5,
              4'd3,4'd15,4'd7,4'd14,4'd9,4'd8,4'd12,4'd2};
        return t[x];
    endfunction

endpackage

@@ rtl/core/spn_round.sv @@
// one shared round datapath: byte box, key xor, nibble box, transpose
module spn_round
    import spn_pkg::*;
(
    input  logic [127:0] i_blk,
    input  logic [127:0] i_key,
    input  logic         i_dec,
    input  logic         i_xpose,
    output logic [127:0] o_blk
);

    logic [127:0] s_a;
    logic [127:0] s_b;

    function automatic logic [127:0] xpose(input logic [127:0] x);
        logic [127:0] y;
        y = '0;
        for (int j = 0; j < 8; j++) begin
            for (int p = 0; p < 16; p++) begin
                y[127 - 16*j - p] = x[127 - 16*j - (4*(p % 4) + p / 4)];
            end
        end
        return y;
    endfunction

    // encrypt: sbox, key, nib, transpose; decrypt: transpose, nibinv, key, invbox
    always_comb begin
        s_a = i_blk;
        s_b = '0;
        o_blk = '0;
        if (!i_dec) begin
            for (int i = 0; i < 16; i++) begin
                s_a[127-8*i -: 8] = fwd_sbox(i_blk[127-8*i -: 8]) ^ i_key[127-8*i -: 8];
            end
            for (int n = 0; n < 32; n++) begin
                s_b[127-4*n -: 4] = nib_fwd(s_a[127-4*n -: 4]);
            end
            o_blk = i_xpose ? xpose(s_b) : s_b;
        end else begin
            s_a = i_xpose ? xpose(i_blk) : i_blk;
            for (int n = 0; n < 32; n++) begin
                s_b[127-4*n -: 4] = nib_inv(s_a[127-4*n -: 4]);
            end
            for (int i = 0; i < 16; i++) begin
                o_blk[127-8*i -: 8] = inv_sbox(s_b[127-8*i -: 8] ^ i_key[127-8*i -: 8]);
            end
        end
    end

endmodule

@@ rtl/core/spn_block_cipher_cbc_top.sv @@
// channel | direction | payload    | handshake
// in      | input     | t_in_item  | i_in_valid / o_in_stall
// out     | output    | t_out_item | o_out_valid / i_out_stall
// key loads, chain clears and non-completing bytes are taken without leaving idle
// a completing byte starts a block: a key-read state, ROUNDS rounds through the
// shared round unit, a final key state when encrypting, then 16 output transactions
// round keys live in a 16-byte-wide memory, one row read per cycle
// reset clears chain, buffer, count and control; key memory is not cleared
// the input stalls while a block is being processed or delivered
module spn_block_cipher_cbc_top
    import spn_pkg::*;
#(
    parameter int ROUNDS = ROUNDS_DEF
)(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    localparam int KROWS = ROUNDS + 1;
    localparam int KW    = $clog2(KROWS);

    // key memory: one row per round key
    logic [127:0] r_kmem [KROWS];
    logic [127:0] r_krow;
    logic [KW-1:0] s_kaddr;

    t_state       r_state, n_state;
    logic [127:0] r_chain;
    logic [127:0] r_buf;
    logic [127:0] r_blk;
    logic [127:0] r_saved;
    logic [3:0]   r_cnt;
    logic [KW-1:0] r_rnd;
    logic         r_dec;
    logic [3:0]   r_ocnt;

    logic         s_acc;
    logic [127:0] s_rout;
    logic [127:0] s_buf_nx;
    logic         s_xpose;

    assign s_acc      = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != ST_IDLE);

    // key row write, byte masked
    always_ff @(posedge i_clk) begin
        if (s_acc && i_in_data.func == FN_KEY && 32'(i_in_data.key_round) <= ROUNDS) begin
            r_kmem[KW'(i_in_data.key_round)][127 - 8*i_in_data.key_byte_index -: 8]
                <= i_in_data.data_byte;
        end
        r_krow <= r_kmem[s_kaddr];
    end

    always_comb begin
        s_buf_nx = r_buf;
        s_buf_nx[127 - 8*r_cnt -: 8] = i_in_data.data_byte;
    end

    // encrypt: round r uses key r, then final xor key ROUNDS
    // decrypt: first xor key ROUNDS, rounds use keys ROUNDS-1 down to 0
    // address is the key needed in the following cycle
    always_comb begin
        if (r_state == ST_IDLE) begin
            s_kaddr = KW'(ROUNDS);
        end else if (r_dec && r_rnd != '0) begin
            s_kaddr = r_rnd - 1'b1;
        end else begin
            s_kaddr = r_rnd;
        end
    end

    // first decrypt round has no transpose, last encrypt round none
    assign s_xpose = r_dec ? (r_rnd != KW'(ROUNDS - 1)) : (r_rnd != KW'(ROUNDS));

    spn_round u_round (
        .i_blk   (r_blk),
        .i_key   (r_krow),
        .i_dec   (r_dec),
        .i_xpose (s_xpose),
        .o_blk   (s_rout)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (s_acc && (i_in_data.func == FN_ENC || i_in_data.func == FN_DEC)
                    && r_cnt == 4'd15) begin
                    n_state = ST_KEYRD;
                end
            end
            ST_KEYRD: n_state = ST_ROUND;
            ST_ROUND: begin
                if (r_dec ? (r_rnd == '0) : (r_rnd == KW'(ROUNDS))) begin
                    n_state = r_dec ? ST_OUT : ST_FINAL;
                end
            end
            ST_FINAL: n_state = ST_OUT;
            ST_OUT: begin
                if (!i_out_stall && r_ocnt == 4'd15) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chain <= '0;
            r_buf   <= '0;
            r_cnt   <= '0;
            r_rnd   <= '0;
            r_dec   <= 1'b0;
            r_ocnt  <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    r_ocnt <= '0;
                    if (s_acc) begin
                        if (i_in_data.func == FN_CLR) begin
                            r_chain <= '0;
                        end else if (i_in_data.func != FN_KEY) begin
                            r_buf <= s_buf_nx;
                            r_cnt <= r_cnt + 4'd1;
                            if (r_cnt == 4'd15) begin
                                r_dec <= (i_in_data.func == FN_DEC);
                                for (int i = 0; i < 16; i++) begin
                                    r_blk[127-8*i -: 8] <= fwd_sbox(s_buf_nx[127-8*i -: 8]);
                                end
                                // decrypt reads the outer key first
                                r_rnd <= (i_in_data.func == FN_DEC) ? KW'(ROUNDS) : '0;
                            end
                        end
                    end
                end
                ST_KEYRD: begin
                    if (r_dec) begin
                        // outer key row is in r_krow now
                        r_saved <= r_blk;
                        r_blk   <= r_blk ^ r_krow;
                        r_rnd   <= KW'(ROUNDS - 1);
                    end else begin
                        r_blk <= r_blk ^ r_chain;
                        r_rnd <= r_rnd + 1'b1;
                    end
                end
                ST_ROUND: begin
                    if (r_dec) begin
                        if (r_rnd == '0) begin
                            r_blk   <= s_rout ^ r_chain;
                            r_chain <= r_saved;
                        end else begin
                            r_blk <= s_rout;
                            r_rnd <= r_rnd - 1'b1;
                        end
                    end else begin
                        r_blk <= s_rout;
                        if (r_rnd != KW'(ROUNDS)) begin
                            r_rnd <= r_rnd + 1'b1;
                        end
                    end
                end
                ST_FINAL: begin
                    r_blk   <= r_blk ^ r_krow;
                    r_chain <= r_blk ^ r_krow;
                end
                ST_OUT: begin
                    if (!i_out_stall) begin
                        r_ocnt <= r_ocnt + 4'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    // key read is registered ahead of use: address tracks the next round
    assign o_out_valid = (r_state == ST_OUT);
    always_comb begin
        o_out_data.result_byte   = inv_sbox(r_blk[127 - 8*r_ocnt -: 8]);
        o_out_data.last_of_block = (r_ocnt == 4'd15);
    end

endmodule

@@ rtl/core/spn_checker.sv @@
module spn_checker
    import spn_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      o_in_stall,
    input  logic      o_out_valid,
    input  logic      i_out_stall,
    input  t_out_item o_out_data
);

    // no input taken while results are pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input open during output");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled output changed");

    // after the last byte of a block, output ends
    a_last_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && o_out_data.last_of_block |=> !o_out_valid)
        else $error("output after last byte");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind spn_block_cipher_cbc_top spn_checker u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
